/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tcpc_pkg.sv */
// Shared constants and types for the corner-pixel cleanup block.
`timescale 1ns / 1ps
`default_nettype none

package tcpc_pkg;

    localparam int unsigned CFG_INDEX_W  = 8;
    localparam int unsigned CFG_DATA_W   = 11;
    localparam int unsigned ROW_OUT_W    = 10;
    localparam int unsigned COL_OUT_W    = 10;
    localparam int unsigned S_TDATA_W    = 8;
    localparam int unsigned M_TDATA_W    = 24;
    localparam int unsigned M_TDATA_PAD  = M_TDATA_W - 1 - ROW_OUT_W - COL_OUT_W;
    localparam int unsigned WIN_DIM      = 5;
    localparam int unsigned WIN_BITS     = WIN_DIM * WIN_DIM;
    localparam int unsigned WIN_CENTER   = (WIN_BITS - 1) / 2;
    localparam int unsigned LINE_SLOTS   = 5;
    localparam int unsigned SLOT_W       = 3;
    localparam int unsigned MIN_DIM      = 5;
    localparam int unsigned WIDTH_RESET  = 640;
    localparam int unsigned HEIGHT_RESET = 480;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam cfg_index_t REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // col_ok: column offsets -2, -1, +1, +2 lie inside the image
    typedef struct packed {
        logic [3:0] col_ok;
        logic       interior;
        logic       last;
    } geom_t;

endpackage

`default_nettype wire

/* rtl/tcpc_line_mem.sv */
// Line memory: one word per column, one bit per row slot, registered read.
`timescale 1ns / 1ps
`default_nettype none

module tcpc_line_mem #(
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                          aclk,
    input  wire logic                          we,
    input  wire logic [tcpc_pkg::SLOT_W-1:0]   wslot,
    input  wire logic                          wbit,
    input  wire logic                          re,
    input  wire logic [ADDR_W-1:0]             addr,
    output logic      [tcpc_pkg::LINE_SLOTS-1:0] rdata
);
    import tcpc_pkg::*;

    logic [LINE_SLOTS-1:0] line_mem [DEPTH];
    logic [LINE_SLOTS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            line_mem[addr][wslot] <= wbit;
        end
        if (re) begin
            rdata_reg <= line_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/tcpc_corner_check.sv */
// Window edge masking and the corner-pixel clear test for the center pixel.
`timescale 1ns / 1ps
`default_nettype none

module tcpc_corner_check (
    input  wire logic [tcpc_pkg::WIN_BITS-1:0] window,
    input  wire tcpc_pkg::geom_t               geom,
    output logic                               pixel
);
    import tcpc_pkg::*;

    logic [WIN_BITS-1:0] win;
    logic [3:0]          nb_cnt [9];
    logic [3:0]          threes;
    logic [3:0]          fours;
    logic                clear;

    always_comb begin
        win = window;
        for (int k = 0; k < WIN_DIM; k++) begin
            win[k*WIN_DIM + 0] = window[k*WIN_DIM + 0] & geom.col_ok[0];
            win[k*WIN_DIM + 1] = window[k*WIN_DIM + 1] & geom.col_ok[1];
            win[k*WIN_DIM + 3] = window[k*WIN_DIM + 3] & geom.col_ok[2];
            win[k*WIN_DIM + 4] = window[k*WIN_DIM + 4] & geom.col_ok[3];
        end
    end

    // neighbour counts of the center and its eight neighbours
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                nb_cnt[r*3 + c] = '0;
                for (int a = 0; a < 3; a++) begin
                    for (int b = 0; b < 3; b++) begin
                        if (a != 1 || b != 1) begin
                            nb_cnt[r*3 + c] = nb_cnt[r*3 + c]
                                            + 4'(win[(r + a)*WIN_DIM + (c + b)]);
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        threes = '0;
        fours  = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r != 1 || c != 1) && win[(r + 1)*WIN_DIM + (c + 1)]) begin
                    if (nb_cnt[r*3 + c] == 4'd3) begin
                        threes = threes + 4'd1;
                    end else if (nb_cnt[r*3 + c] == 4'd4) begin
                        fours = fours + 4'd1;
                    end
                end
            end
        end
        clear = win[WIN_CENTER] && (nb_cnt[4] == 4'd3) && (threes == 4'd2)
                && (fours == 4'd1);
        pixel = win[WIN_CENTER] & ~(geom.interior & clear);
    end

endmodule

`default_nettype wire

/* rtl/thinning_corner_pixel_cleanup.sv */
// Top level of the skeleton corner-pixel cleanup block.
// Throughput: one beat per cycle on the input unless the output stalls; each beat taken reads the
// line memory, and writes it only inside the image. A pixel leaves once the beat two rows and two
// columns beyond it completes its window, via line memory read, window shift, result register.
// Reset (aresetn low at a clock edge): pipeline empties, position goes to row 0 column 0,
// size to 640x480; the line memory keeps its contents, rows outside the frame are masked.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module thinning_corner_pixel_cleanup #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tcpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tcpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [tcpc_pkg::S_TDATA_W-1:0]     s_tdata,   // [0] pixel_in
    input  wire logic [0:0]                         s_tuser,   // [0] op
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [tcpc_pkg::M_TDATA_W-1:0]          m_tdata,   // [0] pixel_out, [10:1] row_out,
                                                               // [20:11] col_out
    output logic                                    m_tlast    // last
);
    import tcpc_pkg::*;

    localparam int COL_W       = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 3);
    localparam int HGT_W       = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_INIT  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int HEIGHT_INIT = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    // configuration and stream position
    logic [COL_W-1:0]  width_reg;
    logic [HGT_W-1:0]  height_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [SLOT_W-1:0] slot_next;

    logic [31:0]       cfg_value;
    logic [COL_W-1:0]  width_cfg;
    logic [HGT_W-1:0]  height_cfg;
    logic              cfg_hit;
    logic              cfg_wr_width;
    logic              cfg_wr_height;

    // input side
    logic              out_ready;
    logic              s2_ready;
    logic              s1_ready;
    logic              in_hit;
    logic              in_image;
    logic              take;
    logic [ROW_W-1:0]  height_ext;
    logic              wrap;
    logic              emit;
    logic [ROW_W-1:0]  tr;
    logic [COL_W-1:0]  tc;
    logic [COL_W-1:0]  col_inc;
    geom_t             geom;
    logic [WIN_DIM-1:0] row_mask;
    logic [LINE_SLOTS-1:0] mem_rdata;

    // stage 1: memory read data and target of the beat
    logic                 s1_valid_reg;
    logic                 s1_px_reg;
    logic [SLOT_W-1:0]    s1_slot_reg;
    logic [WIN_DIM-1:0]   s1_row_mask_reg;
    logic                 s1_emit_reg;
    geom_t                s1_geom_reg;
    logic [ROW_OUT_W-1:0] s1_tr_reg;
    logic [COL_OUT_W-1:0] s1_tc_reg;
    logic [WIN_DIM-1:0]   col_vec;
    logic [3:0]           slot_idx;
    logic                 s1_move;

    // stage 2: window
    logic                 s2_valid_reg;
    logic                 s2_emit_reg;
    geom_t                s2_geom_reg;
    logic [ROW_OUT_W-1:0] s2_tr_reg;
    logic [COL_OUT_W-1:0] s2_tc_reg;
    logic [WIN_BITS-1:0]  window_reg;
    logic [WIN_BITS-1:0]  window_next;
    logic                 pixel_val;

    // result register
    logic                 m_tvalid_reg;
    logic                 m_pixel_reg;
    logic [ROW_OUT_W-1:0] m_row_reg;
    logic [COL_OUT_W-1:0] m_col_reg;
    logic                 m_last_reg;

    // ---------------- configuration ----------------
    assign cfg_ready     = 1'b1;
    assign cfg_hit       = cfg_valid && cfg_ready;
    assign cfg_wr_width  = cfg_hit && (cfg_index == REG_IMAGE_WIDTH);
    assign cfg_wr_height = cfg_hit && (cfg_index == REG_IMAGE_HEIGHT);
    assign cfg_value     = 32'(cfg_data);

    always_comb begin
        if (cfg_value < 32'(MIN_DIM)) begin
            width_cfg  = COL_W'(MIN_DIM);
            height_cfg = HGT_W'(MIN_DIM);
        end else begin
            width_cfg  = (cfg_value > 32'(MAX_WIDTH))  ? COL_W'(MAX_WIDTH)  : COL_W'(cfg_value);
            height_cfg = (cfg_value > 32'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : HGT_W'(cfg_value);
        end
    end

    // ---------------- handshake ----------------
    assign out_ready = !m_tvalid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || !s2_emit_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;
    assign in_hit    = s_tvalid && s_tready;
    assign height_ext = ROW_W'(height_reg);
    assign in_image  = row_reg < height_ext;
    // drop a flush while pixels are still expected
    assign take      = in_hit && !(in_image && (s_tuser[0] == OP_FLUSH));

    // ---------------- target of this beat ----------------
    always_comb begin
        wrap = col_reg < COL_W'(2);
        if (wrap) begin
            tr   = row_reg - ROW_W'(3);
            emit = row_reg >= ROW_W'(3);
            tc   = col_reg + width_reg - COL_W'(2);
        end else begin
            tr   = row_reg - ROW_W'(2);
            emit = row_reg >= ROW_W'(2);
            tc   = col_reg - COL_W'(2);
        end
        geom.col_ok[0] = tc >= COL_W'(2);
        geom.col_ok[1] = tc >= COL_W'(1);
        geom.col_ok[2] = tc < width_reg - COL_W'(1);
        geom.col_ok[3] = tc < width_reg - COL_W'(2);
        geom.interior  = (tr >= ROW_W'(1)) && (tr < height_ext - ROW_W'(1))
                         && (tc >= COL_W'(1)) && (tc < width_reg - COL_W'(1));
        geom.last      = (tr == height_ext - ROW_W'(1)) && (tc == width_reg - COL_W'(1));
        for (int d = 0; d < WIN_DIM; d++) begin
            row_mask[d] = (row_reg >= ROW_W'(d))
                          && ({1'b0, row_reg} < ({1'b0, height_ext} + (ROW_W + 1)'(d)));
        end
    end

    // ---------------- position ----------------
    assign col_inc = col_reg + COL_W'(1);

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        slot_next = slot_reg;
        if (take) begin
            if (emit && geom.last) begin
                col_next  = '0;
                row_next  = '0;
                slot_next = '0;
            end else if (col_inc >= width_reg) begin
                col_next  = '0;
                row_next  = row_reg + ROW_W'(1);
                slot_next = (slot_reg == SLOT_W'(LINE_SLOTS - 1)) ? '0
                                                                  : slot_reg + SLOT_W'(1);
            end else begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= COL_W'(WIDTH_INIT);
            height_reg <= HGT_W'(HEIGHT_INIT);
            col_reg    <= '0;
            row_reg    <= '0;
            slot_reg   <= '0;
        end else if (cfg_wr_width || cfg_wr_height) begin
            if (cfg_wr_width) begin
                width_reg <= width_cfg;
            end
            if (cfg_wr_height) begin
                height_reg <= height_cfg;
            end
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // ---------------- line memory ----------------
    tcpc_line_mem #(
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .aclk  (aclk),
        .we    (take && in_image),
        .wslot (slot_reg),
        .wbit  (s_tdata[0]),
        .re    (take),
        .addr  (col_reg[ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    // ---------------- stage 1 ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_px_reg       <= s_tdata[0];
            s1_slot_reg     <= slot_reg;
            s1_row_mask_reg <= row_mask;
            s1_emit_reg     <= emit;
            s1_geom_reg     <= geom;
            s1_tr_reg       <= ROW_OUT_W'(tr);
            s1_tc_reg       <= COL_OUT_W'(tc);
        end
    end

    // column entering the window: bit k is row (beat row - 4 + k)
    always_comb begin
        slot_idx = '0;
        col_vec[WIN_DIM-1] = s1_row_mask_reg[0] & s1_px_reg;
        for (int d = 1; d < WIN_DIM; d++) begin
            slot_idx = 4'(s1_slot_reg) + 4'(LINE_SLOTS - d);
            if (slot_idx >= 4'(LINE_SLOTS)) begin
                slot_idx = slot_idx - 4'(LINE_SLOTS);
            end
            col_vec[WIN_DIM-1-d] = s1_row_mask_reg[d] & mem_rdata[slot_idx[SLOT_W-1:0]];
        end
    end

    assign s1_move = s1_valid_reg && s2_ready;

    // ---------------- stage 2 ----------------
    always_comb begin
        for (int k = 0; k < WIN_DIM; k++) begin
            for (int c = 0; c < WIN_DIM - 1; c++) begin
                window_next[k*WIN_DIM + c] = window_reg[k*WIN_DIM + c + 1];
            end
            window_next[k*WIN_DIM + WIN_DIM - 1] = col_vec[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            window_reg  <= window_next;
            s2_emit_reg <= s1_emit_reg;
            s2_geom_reg <= s1_geom_reg;
            s2_tr_reg   <= s1_tr_reg;
            s2_tc_reg   <= s1_tc_reg;
        end
    end

    tcpc_corner_check u_corner_check (
        .window (window_reg),
        .geom   (s2_geom_reg),
        .pixel  (pixel_val)
    );

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ready) begin
            m_tvalid_reg <= s2_valid_reg && s2_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s2_valid_reg && s2_emit_reg) begin
            m_pixel_reg <= pixel_val;
            m_row_reg   <= s2_tr_reg;
            m_col_reg   <= s2_tc_reg;
            m_last_reg  <= s2_geom_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_TDATA_PAD{1'b0}}, m_col_reg, m_row_reg, m_pixel_reg};
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    `ASSERT_IMP(a_col_in_row, 1'b1, col_reg < width_reg, "column position beyond image width")
    `ASSERT_NEXT(a_flush_dropped, in_hit && in_image && (s_tuser[0] == OP_FLUSH) && !cfg_valid, $stable(col_reg) && $stable(row_reg), "dropped flush moved the position")
    `ASSERT_IMP(a_last_restarts, s1_valid_reg && s1_emit_reg && s1_geom_reg.last, (col_reg == '0) && (row_reg == '0), "frame did not restart after last pixel")

endmodule

`default_nettype wire

/* bench/thinning_corner_pixel_cleanup_test.sv */
// Self-checking testbench: streamed skeleton frames against a corner-pixel cleanup predictor.
`timescale 1ns / 1ps

module thinning_corner_pixel_cleanup_test;
    import tcpc_pkg::*;

    localparam int unsigned MAX_COLS      = 1024;
    localparam int unsigned MAX_ROWS      = 1024;
    localparam int unsigned RANDOM_BEATS  = 1100;
    localparam int unsigned TAIL_CUT      = 150;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned IDLE_LIMIT    = 4000;
    localparam cfg_index_t  REG_SPARE     = cfg_index_t'(2);
    localparam cfg_index_t  REG_TOP       = '1;

    typedef struct {
        logic       pix;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } cleaned_pixel_t;

    class corner_cleanup_scoreboard;
        int unsigned    width;
        int unsigned    height;
        int             row;
        int             col;
        bit             line_bits[LINE_SLOTS][MAX_COLS];
        cleaned_pixel_t due_pixels[$];
        int unsigned    errors;

        function new();
            width  = WIDTH_RESET;
            height = HEIGHT_RESET;
            row    = 0;
            col    = 0;
            errors = 0;
            foreach (line_bits[i, j]) line_bits[i][j] = 1'b0;
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned hi);
            if (v < MIN_DIM) return MIN_DIM;
            if (v > hi) return hi;
            return v;
        endfunction

        function void note_config(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH) width = clamp_dim(32'(val), MAX_COLS);
            else if (idx == REG_IMAGE_HEIGHT) height = clamp_dim(32'(val), MAX_ROWS);
            else return;
            row = 0;
            col = 0;
        endfunction

        function bit pixel_at(int r, int c);
            if (r < 0 || c < 0 || r >= int'(height) || c >= int'(width)) return 1'b0;
            return line_bits[r % LINE_SLOTS][c];
        endfunction

        function int unsigned count_around(bit [WIN_BITS-1:0] win, int dr, int dc);
            int unsigned n;
            n = 0;
            for (int a = -1; a <= 1; a++)
                for (int b = -1; b <= 1; b++)
                    if (a != 0 || b != 0)
                        n += win[(dr + a + 2) * WIN_DIM + dc + b + 2];
            return n;
        endfunction

        function bit corner_cleared(bit [WIN_BITS-1:0] win);
            int unsigned threes;
            int unsigned fours;
            int unsigned n;
            threes = 0;
            fours  = 0;
            if (!win[WIN_CENTER] || count_around(win, 0, 0) != 3) return 1'b0;
            for (int a = -1; a <= 1; a++)
                for (int b = -1; b <= 1; b++) begin
                    if ((a == 0 && b == 0) || !win[(a + 2) * WIN_DIM + b + 2]) continue;
                    n = count_around(win, a, b);
                    if (n == 3) threes++;
                    else if (n == 4) fours++;
                end
            return threes == 2 && fours == 1;
        endfunction

        function void note_pixel_beat(logic op, logic px);
            int             tr;
            int             tc;
            bit [WIN_BITS-1:0] win;
            cleaned_pixel_t e;
            if (row < int'(height)) begin
                if (op == OP_FLUSH) return;
                line_bits[row % LINE_SLOTS][col] = px;
            end
            if (col >= 2) begin
                tr = row - 2;
                tc = col - 2;
            end else begin
                tr = row - 3;
                tc = col + int'(width) - 2;
            end
            col++;
            if (col >= int'(width)) begin
                col = 0;
                row++;
            end
            if (tr < 0) return;
            for (int dr = -2; dr <= 2; dr++)
                for (int dc = -2; dc <= 2; dc++)
                    win[(dr + 2) * WIN_DIM + dc + 2] = pixel_at(tr + dr, tc + dc);
            e.pix = win[WIN_CENTER];
            if (tr >= 1 && tr + 1 < int'(height) && tc >= 1 && tc + 1 < int'(width))
                if (corner_cleared(win)) e.pix = 1'b0;
            e.row  = tr[9:0];
            e.col  = tc[9:0];
            e.last = (tr + 1 == int'(height)) && (tc + 1 == int'(width));
            if (e.last) begin
                row = 0;
                col = 0;
            end
            due_pixels.push_back(e);
        endfunction

        function void check_pixel_beat(logic [M_TDATA_W-1:0] data, logic tlast);
            cleaned_pixel_t e;
            if (due_pixels.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual pixel %0b row %0d col %0d last %0b",
                         $time, data[0], data[10:1], data[20:11], tlast);
                errors++;
                return;
            end
            e = due_pixels.pop_front();
            if (data[0] !== e.pix) begin
                $display("%0t: pixel_out expected %0b actual %0b (row %0d col %0d)",
                         $time, e.pix, data[0], e.row, e.col);
                errors++;
            end
            if (data[10:1] !== e.row) begin
                $display("%0t: row_out expected %0d actual %0d", $time, e.row, data[10:1]);
                errors++;
            end
            if (data[20:11] !== e.col) begin
                $display("%0t: col_out expected %0d actual %0d", $time, e.col, data[20:11]);
                errors++;
            end
            if (tlast !== e.last) begin
                $display("%0t: last expected %0b actual %0b (row %0d col %0d)",
                         $time, e.last, tlast, e.row, e.col);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    corner_cleanup_scoreboard sb;
    int unsigned burst_left = 0;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned ready_mode = 0;
    int unsigned mode_left = 0;
    int unsigned idle_cycles = 0;

    thinning_corner_pixel_cleanup #(
        .MAX_WIDTH (MAX_COLS),
        .MAX_HEIGHT(MAX_ROWS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_pixel_beat(m_tdata, m_tlast);
        if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 120);
            end
            mode_left--;
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("thinning_corner_pixel_cleanup regression: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_config(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_beat(input logic op, input logic px);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 64);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, px};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel_beat(op, px);
    endtask

    task automatic settle();
        while (sb.due_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // A 2x2 block with one diagonal tail pixel: its far corner is a cleanup candidate.
    task automatic run_frame(input int unsigned density, input int unsigned motifs,
                             input int unsigned cut, input int unsigned noise_pct,
                             output int unsigned beats);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned r0;
        int unsigned c0;
        bit          img[];
        w = sb.width;
        h = sb.height;
        total = (cut != 0 && cut < w * h) ? cut : w * h;
        img = new[w * h];
        foreach (img[i]) img[i] = ($urandom_range(0, 99) < density);
        repeat (motifs) begin
            r0 = $urandom_range(0, h - 4);
            c0 = $urandom_range(0, w - 4);
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    img[(r0 + r) * w + c0 + c] = 1'b0;
            img[r0 * w + c0] = 1'b1;
            for (int r = 1; r < 3; r++)
                for (int c = 1; c < 3; c++)
                    img[(r0 + r) * w + c0 + c] = 1'b1;
        end
        beats = 0;
        for (int unsigned i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_beat(OP_FLUSH, 1'($urandom_range(0, 1)));
            send_beat(OP_PIXEL, img[i]);
            beats++;
        end
        if (total == w * h) begin
            repeat (2 * w + 2) begin
                send_beat($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL,
                          1'($urandom_range(0, 1)));
                beats++;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        int unsigned beats;
        int unsigned frame_beats;
        int unsigned frames;
        int unsigned w_val;
        int unsigned h_val;
        int unsigned density;
        int unsigned cut;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        run_frame(50, 0, 40, 10, frame_beats);
        settle();
        write_reg(REG_SPARE, CFG_DATA_W'(9));
        write_reg(REG_TOP, '1);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(5));
        run_frame(0, 1, 0, 20, frame_beats);

        beats = 0;
        frames = 0;
        while (beats < RANDOM_BEATS) begin
            settle();
            case ($urandom_range(0, 9))
                0: begin
                    w_val = $urandom_range(0, 4);
                    h_val = $urandom_range(5, 12);
                end
                1: begin
                    w_val = $urandom_range(5, 14);
                    h_val = $urandom_range(0, 4);
                end
                default: begin
                    w_val = $urandom_range(5, 14);
                    h_val = $urandom_range(5, 12);
                end
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
                1: write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
                default: begin
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_val));
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_val));
                end
            endcase
            case ($urandom_range(0, 5))
                0: density = 0;
                1: density = 15;
                2: density = 35;
                3: density = 50;
                4: density = 70;
                default: density = 100;
            endcase
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, sb.width * sb.height - 1) : 0;
            if (frames == 3) begin
                hold_request = 1'b1;
                cut = 0;
            end
            run_frame(density, $urandom_range(0, 2), cut, 6, frame_beats);
            beats += frame_beats;
            frames++;
        end

        settle();
        write_reg(REG_IMAGE_WIDTH, '1);
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(5));
        run_frame(35, 2, TAIL_CUT, 2, frame_beats);
        settle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
        write_reg(REG_IMAGE_HEIGHT, '1);
        run_frame(35, 2, TAIL_CUT, 2, frame_beats);

        while (sb.due_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.due_pixels.size() == 0) begin
            $display("thinning_corner_pixel_cleanup regression: pass");
        end else begin
            $display("thinning_corner_pixel_cleanup regression: fail");
        end
        $finish;
    end

endmodule
